// ----- hdl/rational_bezier_cubic_eval_top_defines.svh -----
// Assertion helpers for the evaluator's top level.
`ifndef RATIONAL_BEZIER_CUBIC_EVAL_TOP_DEFINES_SVH
`define RATIONAL_BEZIER_CUBIC_EVAL_TOP_DEFINES_SVH

// Same-cycle implication, checked only out of reset
`define RBC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only out of reset
`define RBC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/rbc_pkg.sv -----
package rbc_pkg;

    // Field widths
    localparam int T_W      = 17;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 8;
    localparam int W_W      = 32;
    localparam int P_W      = 32;
    localparam int PROD_W   = 64;

    // t = 1.0 in Q1.16
    localparam logic [T_W-1:0] T_ONE = 17'h10000;

    // Divider: quotient bits resolved per pipeline stage
    localparam int DIV_BITS   = 4;
    localparam int DIV_QW     = 32;
    localparam int DIV_STAGES = DIV_QW / DIV_BITS;

    // One node: coefficient, product, sum/abs stages, divider, divider output
    localparam int NODE_LAT = 3 + DIV_STAGES + 1;
    localparam int DEGREE   = 3;
    localparam int NUM_CP   = DEGREE + 1;
    localparam int PIPE_LAT = DEGREE * NODE_LAT;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT0 = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT1 = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT2 = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT3 = 8'd3;

    localparam logic [CFG_W-1:0] WEIGHT_RESET = 16'd256;

    // Weighted point of one de Casteljau node
    typedef struct packed {
        logic [W_W-1:0]        w;
        logic signed [P_W-1:0] x;
        logic signed [P_W-1:0] y;
        logic                  zero;
    } node_t;

endpackage

// ----- hdl/rbc_div.sv -----
// Pipelined restoring divider: |dividend| / divisor, quotient known to fit 32 bits.
// Sign is applied at the end; a zero divisor gives a zero quotient.
module rbc_div (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [rbc_pkg::PROD_W-1:0]    mag,
    input  logic                          neg,
    input  logic [rbc_pkg::W_W-1:0]       dvsr,
    output logic signed [rbc_pkg::P_W-1:0] quo
);

    localparam int NS = rbc_pkg::DIV_STAGES;
    localparam int QW = rbc_pkg::DIV_QW;

    logic [QW-1:0]              rem_reg  [NS];
    logic [QW-1:0]              num_reg  [NS];
    logic [QW-1:0]              q_reg    [NS];
    logic [rbc_pkg::W_W-1:0]    d_reg    [NS];
    logic                       neg_reg  [NS];

    logic [QW-1:0]              rem_next [NS];
    logic [QW-1:0]              num_next [NS];
    logic [QW-1:0]              q_next   [NS];

    logic [QW-1:0]              rem_src  [NS];
    logic [QW-1:0]              num_src  [NS];
    logic [QW-1:0]              q_src    [NS];
    logic [rbc_pkg::W_W-1:0]    d_src    [NS];
    logic                       neg_src  [NS];

    logic signed [rbc_pkg::P_W-1:0] quo_reg;

    // Stage sources: first stage from the ports, others from the stage before
    for (genvar s = 0; s < NS; s++) begin : g_src
        if (s == 0) begin : g_first
            assign rem_src[s] = mag[rbc_pkg::PROD_W-1:QW];
            assign num_src[s] = mag[QW-1:0];
            assign q_src[s]   = '0;
            assign d_src[s]   = dvsr;
            assign neg_src[s] = neg;
        end else begin : g_rest
            assign rem_src[s] = rem_reg[s-1];
            assign num_src[s] = num_reg[s-1];
            assign q_src[s]   = q_reg[s-1];
            assign d_src[s]   = d_reg[s-1];
            assign neg_src[s] = neg_reg[s-1];
        end
    end

    // A few shift-compare-subtract steps per stage
    always_comb begin
        logic [QW-1:0] r;
        logic [QW-1:0] n;
        logic [QW-1:0] q;
        logic [QW:0]   cand;
        logic [QW:0]   diff;
        for (int s = 0; s < NS; s++) begin
            r = rem_src[s];
            n = num_src[s];
            q = q_src[s];
            for (int b = 0; b < rbc_pkg::DIV_BITS; b++) begin
                cand = {r, n[QW-1]};
                n    = {n[QW-2:0], 1'b0};
                diff = cand - {1'b0, d_src[s]};
                if (cand >= {1'b0, d_src[s]}) begin
                    r = diff[QW-1:0];
                    q = {q[QW-2:0], 1'b1};
                end else begin
                    r = cand[QW-1:0];
                    q = {q[QW-2:0], 1'b0};
                end
            end
            rem_next[s] = r;
            num_next[s] = n;
            q_next[s]   = q;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s < NS; s++) begin
                rem_reg[s] <= rem_next[s];
                num_reg[s] <= num_next[s];
                q_reg[s]   <= q_next[s];
                d_reg[s]   <= d_src[s];
                neg_reg[s] <= neg_src[s];
            end
        end
    end

    // Restore sign; zero divisor forces zero
    always_ff @(posedge aclk) begin
        if (en) begin
            if (d_reg[NS-1] == '0) begin
                quo_reg <= '0;
            end else if (neg_reg[NS-1]) begin
                quo_reg <= -$signed(q_reg[NS-1]);
            end else begin
                quo_reg <= $signed(q_reg[NS-1]);
            end
        end
    end

    assign quo = quo_reg;

endmodule

// ----- hdl/rbc_node.sv -----
// One de Casteljau node: mixes two weighted points at parameter t.
module rbc_node (
    input  logic                      aclk,
    input  logic                      en,
    input  logic [rbc_pkg::T_W-1:0]   t_i,
    input  rbc_pkg::node_t            a_i,
    input  rbc_pkg::node_t            b_i,
    output rbc_pkg::node_t            node_o
);

    localparam int WW = rbc_pkg::W_W;
    localparam int PW = rbc_pkg::P_W;
    localparam int XW = rbc_pkg::PROD_W;
    localparam int NL = rbc_pkg::DIV_STAGES + 1;

    // Stage 1: coefficients
    logic [rbc_pkg::T_W-1:0]     u;
    logic [WW+rbc_pkg::T_W-1:0]  mul_a;
    logic [WW+rbc_pkg::T_W-1:0]  mul_b;
    logic [WW-1:0]               ca_reg, cb_reg;
    logic signed [PW-1:0]        xa_reg, ya_reg, xb_reg, yb_reg;
    logic                        z1_reg;

    assign u     = rbc_pkg::T_ONE - t_i;
    assign mul_a = (WW+rbc_pkg::T_W)'(u) * (WW+rbc_pkg::T_W)'(a_i.w);
    assign mul_b = (WW+rbc_pkg::T_W)'(t_i) * (WW+rbc_pkg::T_W)'(b_i.w);

    always_ff @(posedge aclk) begin
        if (en) begin
            ca_reg <= mul_a[WW+15:16];
            cb_reg <= mul_b[WW+15:16];
            xa_reg <= a_i.x;
            ya_reg <= a_i.y;
            xb_reg <= b_i.x;
            yb_reg <= b_i.y;
            z1_reg <= a_i.zero | b_i.zero;
        end
    end

    // Stage 2: node weight and coefficient products
    logic [WW:0]                 nw_sum;
    logic signed [XW:0]          pxa_full, pxb_full, pya_full, pyb_full;
    logic signed [XW-1:0]        pxa_reg, pxb_reg, pya_reg, pyb_reg;
    logic [WW-1:0]               nw2_reg;
    logic                        z2_reg;

    assign nw_sum   = {1'b0, ca_reg} + {1'b0, cb_reg};
    assign pxa_full = (XW+1)'($signed({1'b0, ca_reg})) * (XW+1)'(xa_reg);
    assign pxb_full = (XW+1)'($signed({1'b0, cb_reg})) * (XW+1)'(xb_reg);
    assign pya_full = (XW+1)'($signed({1'b0, ca_reg})) * (XW+1)'(ya_reg);
    assign pyb_full = (XW+1)'($signed({1'b0, cb_reg})) * (XW+1)'(yb_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            pxa_reg <= pxa_full[XW-1:0];
            pxb_reg <= pxb_full[XW-1:0];
            pya_reg <= pya_full[XW-1:0];
            pyb_reg <= pyb_full[XW-1:0];
            nw2_reg <= nw_sum[WW-1:0];
            z2_reg  <= z1_reg;
        end
    end

    // Stage 3: numerators, split into sign and magnitude
    logic signed [XW-1:0]        nx, ny;
    logic [XW-1:0]               magx_reg, magy_reg;
    logic                        negx_reg, negy_reg;
    logic [WW-1:0]               nw3_reg;
    logic                        z3_reg;

    assign nx = pxa_reg + pxb_reg;
    assign ny = pya_reg + pyb_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            negx_reg <= nx[XW-1];
            negy_reg <= ny[XW-1];
            magx_reg <= nx[XW-1] ? XW'(-nx) : XW'(nx);
            magy_reg <= ny[XW-1] ? XW'(-ny) : XW'(ny);
            nw3_reg  <= nw2_reg;
            z3_reg   <= z2_reg | (nw2_reg == '0);
        end
    end

    // Division of both coordinates by the node weight
    logic signed [PW-1:0]        qx, qy;

    rbc_div u_div_x (
        .aclk (aclk),
        .en   (en),
        .mag  (magx_reg),
        .neg  (negx_reg),
        .dvsr (nw3_reg),
        .quo  (qx)
    );

    rbc_div u_div_y (
        .aclk (aclk),
        .en   (en),
        .mag  (magy_reg),
        .neg  (negy_reg),
        .dvsr (nw3_reg),
        .quo  (qy)
    );

    // Weight and zero flag ride alongside the divider
    logic [WW-1:0]               nw_line_reg [NL];
    logic                        z_line_reg  [NL];

    always_ff @(posedge aclk) begin
        if (en) begin
            nw_line_reg[0] <= nw3_reg;
            z_line_reg[0]  <= z3_reg;
            for (int i = 1; i < NL; i++) begin
                nw_line_reg[i] <= nw_line_reg[i-1];
                z_line_reg[i]  <= z_line_reg[i-1];
            end
        end
    end

    assign node_o.w    = nw_line_reg[NL-1];
    assign node_o.x    = qx;
    assign node_o.y    = qy;
    assign node_o.zero = z_line_reg[NL-1];

endmodule

// ----- hdl/rational_bezier_cubic_eval_top.sv -----
// Cubic rational Bezier evaluator. Each transaction carries t (Q1.16, values above
// 1.0 clamp to 1.0) and four Q16.16 control points; the four Q8.8 weights come from
// the configuration registers (reset 1.0, write only while idle). One curve point is
// returned per transaction, in order. The pipeline takes one transaction every cycle
// while not stalled; each one passes three node levels (coefficients, products,
// sums, an 8-stage divider resolving 4 quotient bits per stage, sign fix) plus the
// output register. If any node weight is zero, zero_weight is set and the point is 0.
// A result waiting at the output stalls the whole pipeline while its last stage holds
// a finished transaction; bubbles further up are not squeezed out.
`include "rational_bezier_cubic_eval_top_defines.svh"

module rational_bezier_cubic_eval_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [rbc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rbc_pkg::CFG_W-1:0]           cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [rbc_pkg::T_W-1:0]             s_param_t,
    input  logic signed [rbc_pkg::P_W-1:0]      s_px0,
    input  logic signed [rbc_pkg::P_W-1:0]      s_py0,
    input  logic signed [rbc_pkg::P_W-1:0]      s_px1,
    input  logic signed [rbc_pkg::P_W-1:0]      s_py1,
    input  logic signed [rbc_pkg::P_W-1:0]      s_px2,
    input  logic signed [rbc_pkg::P_W-1:0]      s_py2,
    input  logic signed [rbc_pkg::P_W-1:0]      s_px3,
    input  logic signed [rbc_pkg::P_W-1:0]      s_py3,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [rbc_pkg::P_W-1:0]      m_curve_x,
    output logic signed [rbc_pkg::P_W-1:0]      m_curve_y,
    output logic                                m_zero_weight
);

    localparam int NL = rbc_pkg::NODE_LAT;
    localparam int PL = rbc_pkg::PIPE_LAT;

    // Weight registers
    logic [rbc_pkg::CFG_W-1:0] weight_reg [rbc_pkg::NUM_CP];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < rbc_pkg::NUM_CP; i++) begin
                weight_reg[i] <= rbc_pkg::WEIGHT_RESET;
            end
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                rbc_pkg::REG_WEIGHT0: weight_reg[0] <= cfg_wdata;
                rbc_pkg::REG_WEIGHT1: weight_reg[1] <= cfg_wdata;
                rbc_pkg::REG_WEIGHT2: weight_reg[2] <= cfg_wdata;
                rbc_pkg::REG_WEIGHT3: weight_reg[3] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Pipeline flow control
    logic vld_line_reg [PL];
    logic vld_last;
    logic out_load;
    logic en;
    logic m_valid_reg;

    assign vld_last = vld_line_reg[PL-1];
    assign out_load = m_ready || !m_valid_reg;
    assign en       = out_load || !vld_last;
    assign s_ready  = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PL; i++) begin
                vld_line_reg[i] <= 1'b0;
            end
        end else if (en) begin
            vld_line_reg[0] <= s_valid;
            for (int i = 1; i < PL; i++) begin
                vld_line_reg[i] <= vld_line_reg[i-1];
            end
        end
    end

    // Clamped t, delayed to the start of each later level
    logic [rbc_pkg::T_W-1:0] t_sat;
    logic [rbc_pkg::T_W-1:0] t_line_reg [2*NL];

    assign t_sat = (s_param_t > rbc_pkg::T_ONE) ? rbc_pkg::T_ONE : s_param_t;

    always_ff @(posedge aclk) begin
        if (en) begin
            t_line_reg[0] <= t_sat;
            for (int i = 1; i < 2*NL; i++) begin
                t_line_reg[i] <= t_line_reg[i-1];
            end
        end
    end

    // Control points with weights widened to Q8.24
    rbc_pkg::node_t lvl0 [rbc_pkg::NUM_CP];
    rbc_pkg::node_t lvl1 [3];
    rbc_pkg::node_t lvl2 [2];
    rbc_pkg::node_t lvl3;

    assign lvl0[0] = '{w: {weight_reg[0], 16'h0}, x: s_px0, y: s_py0, zero: 1'b0};
    assign lvl0[1] = '{w: {weight_reg[1], 16'h0}, x: s_px1, y: s_py1, zero: 1'b0};
    assign lvl0[2] = '{w: {weight_reg[2], 16'h0}, x: s_px2, y: s_py2, zero: 1'b0};
    assign lvl0[3] = '{w: {weight_reg[3], 16'h0}, x: s_px3, y: s_py3, zero: 1'b0};

    // Level 1
    for (genvar k = 0; k < 3; k++) begin : g_lvl1
        rbc_node u_node (
            .aclk   (aclk),
            .en     (en),
            .t_i    (t_sat),
            .a_i    (lvl0[k]),
            .b_i    (lvl0[k+1]),
            .node_o (lvl1[k])
        );
    end

    // Level 2
    for (genvar k = 0; k < 2; k++) begin : g_lvl2
        rbc_node u_node (
            .aclk   (aclk),
            .en     (en),
            .t_i    (t_line_reg[NL-1]),
            .a_i    (lvl1[k]),
            .b_i    (lvl1[k+1]),
            .node_o (lvl2[k])
        );
    end

    // Level 3: the curve point
    rbc_node u_lvl3 (
        .aclk   (aclk),
        .en     (en),
        .t_i    (t_line_reg[2*NL-1]),
        .a_i    (lvl2[0]),
        .b_i    (lvl2[1]),
        .node_o (lvl3)
    );

    // Output register; a convex mix stays in Q16.16 range, so no clipping is needed
    logic signed [rbc_pkg::P_W-1:0] curve_x_reg, curve_y_reg;
    logic                           zero_weight_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= vld_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            curve_x_reg     <= lvl3.zero ? '0 : lvl3.x;
            curve_y_reg     <= lvl3.zero ? '0 : lvl3.y;
            zero_weight_reg <= lvl3.zero;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_curve_x     = curve_x_reg;
    assign m_curve_y     = curve_y_reg;
    assign m_zero_weight = zero_weight_reg;

    // Checks
    `RBC_ASSERT_IMP(a_full_stall, m_valid && !m_ready && vld_last, !s_ready, "input taken while pipeline full")
    `RBC_ASSERT_NXT(a_result_lands, vld_last && out_load, m_valid, "finished transaction dropped")
    `RBC_ASSERT_IMP(a_zero_point, m_valid && m_zero_weight, m_curve_x == '0 && m_curve_y == '0, "zero weight point not cleared")

endmodule

// ----- tb/testbench.sv -----
module testbench;

    // One curve evaluation request
    typedef struct {
        logic [rbc_pkg::T_W-1:0]        t;
        logic signed [rbc_pkg::P_W-1:0] px [4];
        logic signed [rbc_pkg::P_W-1:0] py [4];
    } bez_req_t;

    typedef struct {
        logic signed [rbc_pkg::P_W-1:0] x;
        logic signed [rbc_pkg::P_W-1:0] y;
        logic                           zw;
    } curve_pt_t;

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             cfg_wr_en = 1'b0;
    logic [rbc_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
    logic [rbc_pkg::CFG_W-1:0]        cfg_wdata = '0;
    logic                             s_valid = 1'b0;
    logic                             s_ready;
    logic [rbc_pkg::T_W-1:0]          s_param_t = '0;
    logic signed [rbc_pkg::P_W-1:0]   s_px0 = '0, s_py0 = '0, s_px1 = '0, s_py1 = '0;
    logic signed [rbc_pkg::P_W-1:0]   s_px2 = '0, s_py2 = '0, s_px3 = '0, s_py3 = '0;
    logic                             m_valid;
    logic                             m_ready = 1'b0;
    logic signed [rbc_pkg::P_W-1:0]   m_curve_x, m_curve_y;
    logic                             m_zero_weight;

    bez_req_t  req_q [$];
    curve_pt_t expected_pts [$];
    logic [15:0] weights [4];
    int        n_errors = 0;
    int        n_points = 0;
    int        n_zero = 0;
    int        send_gap = 0;
    int        recv_gap = 0;

    always #5 aclk = ~aclk;

    rational_bezier_cubic_eval_top u_top (.*);

    // Rational de Casteljau in exact integer arithmetic
    function automatic curve_pt_t eval_curve(bez_req_t r);
        logic [63:0] tt, uu, ca, cb, nw;
        logic [63:0] w [4];
        longint x [4], y [4];
        longint nx, ny;
        bit zero;
        curve_pt_t res;
        tt = {47'd0, r.t};
        if (tt > 64'd65536) tt = 64'd65536;
        uu = 64'd65536 - tt;
        zero = 1'b0;
        for (int k = 0; k < 4; k++) begin
            w[k] = {32'd0, weights[k], 16'd0};
            x[k] = r.px[k];
            y[k] = r.py[k];
        end
        for (int lvl = 1; lvl <= 3; lvl++) begin
            for (int k = 0; k <= 3 - lvl; k++) begin
                ca = (uu * w[k]) >> 16;
                cb = (tt * w[k+1]) >> 16;
                nw = ca + cb;
                if (nw == 0) begin
                    zero = 1'b1;
                    x[k] = 0;
                    y[k] = 0;
                end else begin
                    nx = longint'(ca) * x[k] + longint'(cb) * x[k+1];
                    ny = longint'(ca) * y[k] + longint'(cb) * y[k+1];
                    x[k] = nx / longint'(nw);
                    y[k] = ny / longint'(nw);
                end
                w[k] = nw;
            end
        end
        if (zero) begin
            res.x = '0; res.y = '0; res.zw = 1'b1;
        end else begin
            res.x = (x[0] > 64'sd2147483647) ? 32'h7fffffff :
                    (x[0] < -64'sd2147483648) ? 32'h80000000 : x[0][31:0];
            res.y = (y[0] > 64'sd2147483647) ? 32'h7fffffff :
                    (y[0] < -64'sd2147483648) ? 32'h80000000 : y[0][31:0];
            res.zw = 1'b0;
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        n_errors++;
    endtask

    // Driver: one transaction from the queue, random gap after each
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !s_ready) begin
        end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            s_valid <= 1'b0;
        end else if (req_q.size() > 0 && !cfg_wr_en) begin
            bez_req_t r;
            r = req_q.pop_front();
            expected_pts.push_back(eval_curve(r));
            s_valid <= 1'b1;
            s_param_t <= r.t;
            s_px0 <= r.px[0]; s_py0 <= r.py[0];
            s_px1 <= r.px[1]; s_py1 <= r.py[1];
            s_px2 <= r.px[2]; s_py2 <= r.py[2];
            s_px3 <= r.px[3]; s_py3 <= r.py[3];
            send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
        end else begin
            s_valid <= 1'b0;
        end
    end

    // Monitor: compare each accepted point with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            curve_pt_t e;
            if (expected_pts.size() == 0) begin
                report_mismatch("unexpected point", 0, 0);
            end else begin
                e = expected_pts.pop_front();
                if (m_curve_x !== e.x) report_mismatch("curve_x", m_curve_x, e.x);
                if (m_curve_y !== e.y) report_mismatch("curve_y", m_curve_y, e.y);
                if (m_zero_weight !== e.zw)
                    report_mismatch("zero_weight", m_zero_weight, e.zw);
                n_points++;
                if (m_zero_weight) n_zero++;
            end
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (m_valid && m_ready)
                recv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
        end
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(0, 32'h000fffff) - 32'h00080000;
            default: return $urandom;
        endcase
    endfunction

    function automatic bez_req_t rand_req();
        bez_req_t r;
        case ($urandom_range(0, 9))
            0: r.t = 17'h00000;
            1: r.t = rbc_pkg::T_ONE;
            2: r.t = rbc_pkg::T_W'($urandom_range(17'h10001, 17'h1ffff));
            default: r.t = rbc_pkg::T_W'($urandom_range(0, 17'h10000));
        endcase
        for (int k = 0; k < 4; k++) begin
            r.px[k] = rand_coord();
            r.py[k] = rand_coord();
        end
        return r;
    endfunction

    task automatic write_weight(logic [rbc_pkg::CFG_IDX_W-1:0] idx,
                                logic [rbc_pkg::CFG_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx <= rbc_pkg::REG_WEIGHT3) weights[idx[1:0]] = val;
    endtask

    // Let the pipeline drain before touching the weights again
    task automatic wait_idle();
        wait (req_q.size() == 0 && expected_pts.size() == 0 && !s_valid);
        repeat (rbc_pkg::PIPE_LAT + 4) @(posedge aclk);
    endtask

    task automatic set_weights(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                               logic [15:0] d);
        wait_idle();
        write_weight(rbc_pkg::REG_WEIGHT0, a);
        write_weight(rbc_pkg::REG_WEIGHT1, b);
        write_weight(rbc_pkg::REG_WEIGHT2, c);
        write_weight(rbc_pkg::REG_WEIGHT3, d);
    endtask

    // Stimulus
    initial begin
        bez_req_t r;
        for (int k = 0; k < 4; k++) weights[k] = rbc_pkg::WEIGHT_RESET;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: t extremes, t above one, coordinate extremes
        for (int i = 0; i < 12; i++) begin
            r = rand_req();
            r.t = (i % 4 == 0) ? 17'h0 : (i % 4 == 1) ? rbc_pkg::T_ONE :
                  (i % 4 == 2) ? 17'h1ffff : 17'h08000;
            for (int k = 0; k < 4; k++) begin
                r.px[k] = (i < 6) ? 32'h7fffffff : 32'h80000000;
                r.py[k] = (k[0] ^ i[0]) ? 32'h7fffffff : 32'h80000000;
            end
            req_q.push_back(r);
        end
        // zero node weights: w0 zero at t=0, w3 zero at t=1, all zero, unknown index ignored
        set_weights(16'h0, 16'h100, 16'hffff, 16'h0);
        for (int i = 0; i < 6; i++) begin
            r = rand_req();
            r.t = (i < 3) ? 17'h0 : rbc_pkg::T_ONE;
            req_q.push_back(r);
        end
        set_weights(16'h0, 16'h0, 16'h0, 16'h0);
        write_weight(8'd4, 16'h1234);
        write_weight(8'hff, 16'h5678);
        for (int i = 0; i < 4; i++) req_q.push_back(rand_req());

        // random phases over several weight settings
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_weights(16'hffff, 16'hffff, 16'hffff, 16'hffff);
                1: set_weights(16'h0001, 16'hffff, 16'h0001, 16'hffff);
                2: set_weights(rbc_pkg::WEIGHT_RESET, rbc_pkg::WEIGHT_RESET,
                               rbc_pkg::WEIGHT_RESET, rbc_pkg::WEIGHT_RESET);
                default: set_weights(16'($urandom), 16'($urandom), 16'($urandom),
                                     16'($urandom));
            endcase
            for (int i = 0; i < 100; i++) req_q.push_back(rand_req());
        end
        wait_idle();
        $display("covered %0d curve points, %0d with a zero node weight",
                 n_points, n_zero);
        if (n_errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("timeout with %0d points outstanding", expected_pts.size());
        $display("testbench: errors");
        $finish;
    end
endmodule
